// ===== design/tmb_pkg.sv =====
package tmb_pkg;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Default tile limits and register reset value
    localparam int MASK_MAX_WIDTH_DEF  = 64;
    localparam int MASK_MAX_HEIGHT_DEF = 64;
    localparam int MASK_DIM_RESET      = 64;

    // Remainder pipeline: STEPS_PER_STAGE bits of the coordinate per stage
    localparam int STEPS_PER_STAGE = 3;
    localparam int MOD_STAGES      = COORD_W / STEPS_PER_STAGE;

    // floor(v * 29 / 20) == (v * SCALE_MUL) >> SCALE_SHIFT for v in 0..255
    localparam int SCALE_SHIFT = 13;
    localparam int SCALE_W     = 14;
    localparam logic [SCALE_W-1:0] SCALE_MUL = 14'd11879;
    localparam int PROD_W      = CHAN_W + SCALE_W;
    localparam int QUOT_W      = PROD_W - SCALE_SHIFT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_W = 1'b0,
        REG_TILE_H = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_PIXEL = 1'b1
    } item_mode_t;

    function automatic logic [PROD_W-1:0] scale_chan(input logic [CHAN_W-1:0] v);
        return PROD_W'(v) * PROD_W'(SCALE_MUL);
    endfunction

    function automatic logic [CHAN_W-1:0] sat_chan(input logic [PROD_W-1:0] p);
        logic [QUOT_W-1:0] q;
        q = p[PROD_W-1:SCALE_SHIFT];
        if (q > QUOT_W'({CHAN_W{1'b1}}))
        begin
            return {CHAN_W{1'b1}};
        end
        return q[CHAN_W-1:0];
    endfunction

endpackage

// ===== design/tmb_if.sv =====
// Pixel / mask-load transaction channel
interface tmb_pix_if
    import tmb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               mask_dark;

    modport source (output valid, mode, x, y, red, green, blue, mask_dark, input ready);
    modport sink   (input valid, mode, x, y, red, green, blue, mask_dark, output ready);
endinterface

// Result pixel channel
interface tmb_res_if
    import tmb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== design/tmb_ram.sv =====
// Simple dual-port RAM, registered read
module tmb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tiled_mask_brighten_core.sv =====
// Channel  | Dir | Transaction                                  | Handshake
// ---------+-----+----------------------------------------------+--------------
// pixels   | in  | mode 0: mask bit load, mode 1: image pixel   | valid/ready
// results  | out | brightened or passed-through RGB, pixel only | valid/ready
// cfg      | in  | tile width (0), tile height (1)              | cfg_we only
//
// One transaction per clock while the output is not stalled; a pixel passes 8 registers
// (input, 4 remainder stages, RAM read, multiply, output) before its result is valid.
// Remainder stages (3 restoring steps each for x mod w and y mod h) set the depth.
// A load writes the mask RAM as it leaves the last remainder stage and yields no result.
// Each stage advances on its own ready, so bubbles are squeezed out under stall.
// Reset clears valid bits and sets the tile to 64x64 only; mask RAM is junk until loaded.
module tiled_mask_brighten_core
    import tmb_pkg::*;
#(
    parameter int MASK_MAX_WIDTH  = MASK_MAX_WIDTH_DEF,
    parameter int MASK_MAX_HEIGHT = MASK_MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tmb_pix_if.sink               pixels,
    tmb_res_if.source             results
);

    localparam int MAX_DIM = (MASK_MAX_WIDTH > MASK_MAX_HEIGHT) ? MASK_MAX_WIDTH
                                                                : MASK_MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MASK_MAX_WIDTH * MASK_MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_W   = (MASK_DIM_RESET > MASK_MAX_WIDTH) ? MASK_MAX_WIDTH
                                                               : MASK_DIM_RESET;
    localparam int RST_H   = (MASK_DIM_RESET > MASK_MAX_HEIGHT) ? MASK_MAX_HEIGHT
                                                                : MASK_DIM_RESET;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               dark;
        logic [DIM_W-1:0]   rx;
        logic [DIM_W-1:0]   ry;
    } mod_item_t;

    // Zero maps to 1, anything above the store limit maps to the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                   input int maxv);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        if (32'(v) > maxv)
        begin
            return DIM_W'(maxv);
        end
        return DIM_W'(v);
    endfunction

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits
    function automatic logic [DIM_W-1:0] mod_step(input logic [DIM_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIM_W-1:0] d);
        logic [DIM_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[DIM_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Tile size registers (stored already clamped)
    // ---------------------------------------------------------------
    logic [DIM_W-1:0] mask_w_reg;
    logic [DIM_W-1:0] mask_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_w_reg <= DIM_W'(RST_W);
            mask_h_reg <= DIM_W'(RST_H);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TILE_W: mask_w_reg <= clamp_dim(cfg_data, MASK_MAX_WIDTH);
                REG_TILE_H: mask_h_reg <= clamp_dim(cfg_data, MASK_MAX_HEIGHT);
                default:    mask_w_reg <= mask_w_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage ready chain
    // ---------------------------------------------------------------
    logic                  o_vld_reg;
    logic                  p_vld_reg;
    logic                  r_vld_reg;
    logic [MOD_STAGES:0]   mod_vld_reg;
    logic [MOD_STAGES:0]   mod_rdy;
    logic                  o_rdy;
    logic                  p_rdy;
    logic                  r_rdy;

    assign o_rdy = !o_vld_reg || results.ready;
    assign p_rdy = !p_vld_reg || o_rdy;
    assign r_rdy = !r_vld_reg || p_rdy;

    genvar gk;
    generate
        for (gk = 0; gk <= MOD_STAGES; gk++)
        begin : g_rdy
            if (gk == MOD_STAGES)
            begin : g_last
                assign mod_rdy[gk] = !mod_vld_reg[gk] || r_rdy;
            end
            else
            begin : g_mid
                assign mod_rdy[gk] = !mod_vld_reg[gk] || mod_rdy[gk+1];
            end
        end
    endgenerate

    assign pixels.ready = mod_rdy[0];

    // ---------------------------------------------------------------
    // Input register and remainder pipeline (x mod w, y mod h)
    // ---------------------------------------------------------------
    mod_item_t mod_reg  [MOD_STAGES+1];
    mod_item_t mod_next [MOD_STAGES+1];

    always_comb
    begin
        mod_next[0].mode  = pixels.mode;
        mod_next[0].x     = pixels.x;
        mod_next[0].y     = pixels.y;
        mod_next[0].red   = pixels.red;
        mod_next[0].green = pixels.green;
        mod_next[0].blue  = pixels.blue;
        mod_next[0].dark  = pixels.mask_dark;
        mod_next[0].rx    = '0;
        mod_next[0].ry    = '0;
    end

    generate
        for (gk = 1; gk <= MOD_STAGES; gk++)
        begin : g_mod
            // This stage consumes coordinate bits from the MSB end
            always_comb
            begin
                mod_next[gk] = mod_reg[gk-1];
                for (int j = 0; j < STEPS_PER_STAGE; j++)
                begin
                    mod_next[gk].rx = mod_step(mod_next[gk].rx,
                        mod_reg[gk-1].x[COORD_W-1-(gk-1)*STEPS_PER_STAGE-j], mask_w_reg);
                    mod_next[gk].ry = mod_step(mod_next[gk].ry,
                        mod_reg[gk-1].y[COORD_W-1-(gk-1)*STEPS_PER_STAGE-j], mask_h_reg);
                end
            end
        end

        for (gk = 0; gk <= MOD_STAGES; gk++)
        begin : g_mod_reg
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mod_vld_reg[gk] <= 1'b0;
                end
                else if (mod_rdy[gk])
                begin
                    if (gk == 0)
                    begin
                        mod_vld_reg[gk] <= pixels.valid;
                    end
                    else
                    begin
                        mod_vld_reg[gk] <= mod_vld_reg[(gk == 0) ? 0 : gk-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (mod_rdy[gk])
                begin
                    mod_reg[gk] <= mod_next[gk];
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------
    // Mask RAM access: loads write, pixels read, both from the last mod stage
    // ---------------------------------------------------------------
    mod_item_t        tail;
    logic             tail_pixel;
    logic             load_in_range;
    logic [31:0]      waddr32;
    logic [31:0]      raddr32;
    logic             ram_we;
    logic             ram_re;
    logic             ram_rdata;

    assign tail          = mod_reg[MOD_STAGES];
    assign tail_pixel    = (item_mode_t'(tail.mode) == MODE_PIXEL);
    assign load_in_range = (32'(tail.x) < MASK_MAX_WIDTH) && (32'(tail.y) < MASK_MAX_HEIGHT);
    assign waddr32       = 32'(tail.y) * 32'(MASK_MAX_WIDTH) + 32'(tail.x);
    assign raddr32       = 32'(tail.ry) * 32'(MASK_MAX_WIDTH) + 32'(tail.rx);
    assign ram_we        = r_rdy && mod_vld_reg[MOD_STAGES] && !tail_pixel && load_in_range;
    assign ram_re        = r_rdy && mod_vld_reg[MOD_STAGES] && tail_pixel;

    tmb_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr32[AW-1:0]),
        .wdata (tail.dark),
        .re    (ram_re),
        .raddr (raddr32[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // R stage: mask bit arrives from RAM; load transactions end here
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0] r_red_reg;
    logic [CHAN_W-1:0] r_green_reg;
    logic [CHAN_W-1:0] r_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (r_rdy)
        begin
            r_vld_reg <= mod_vld_reg[MOD_STAGES] && tail_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_rdy)
        begin
            r_red_reg   <= tail.red;
            r_green_reg <= tail.green;
            r_blue_reg  <= tail.blue;
        end
    end

    // ---------------------------------------------------------------
    // P stage: gain products
    // ---------------------------------------------------------------
    logic              p_dark_reg;
    logic [CHAN_W-1:0] p_red_reg;
    logic [CHAN_W-1:0] p_green_reg;
    logic [CHAN_W-1:0] p_blue_reg;
    logic [PROD_W-1:0] p_red_prod_reg;
    logic [PROD_W-1:0] p_green_prod_reg;
    logic [PROD_W-1:0] p_blue_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (p_rdy)
        begin
            p_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_rdy)
        begin
            p_dark_reg       <= ram_rdata;
            p_red_reg        <= r_red_reg;
            p_green_reg      <= r_green_reg;
            p_blue_reg       <= r_blue_reg;
            p_red_prod_reg   <= scale_chan(r_red_reg);
            p_green_prod_reg <= scale_chan(r_green_reg);
            p_blue_prod_reg  <= scale_chan(r_blue_reg);
        end
    end

    // ---------------------------------------------------------------
    // O stage: saturate, select, output register
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0] o_red_reg;
    logic [CHAN_W-1:0] o_green_reg;
    logic [CHAN_W-1:0] o_blue_reg;
    logic [CHAN_W-1:0] o_red_next;
    logic [CHAN_W-1:0] o_green_next;
    logic [CHAN_W-1:0] o_blue_next;

    always_comb
    begin
        if (p_dark_reg)
        begin
            o_red_next   = sat_chan(p_red_prod_reg);
            o_green_next = sat_chan(p_green_prod_reg);
            o_blue_next  = sat_chan(p_blue_prod_reg);
        end
        else
        begin
            o_red_next   = p_red_reg;
            o_green_next = p_green_reg;
            o_blue_next  = p_blue_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (o_rdy)
        begin
            o_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy)
        begin
            o_red_reg   <= o_red_next;
            o_green_reg <= o_green_next;
            o_blue_reg  <= o_blue_next;
        end
    end

    assign results.valid     = o_vld_reg;
    assign results.out_red   = o_red_reg;
    assign results.out_green = o_green_reg;
    assign results.out_blue  = o_blue_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // A mask load leaving the last remainder stage never becomes a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (r_rdy && mod_vld_reg[MOD_STAGES] && !tail_pixel) |=> !r_vld_reg)
        else $error("mask load reached the result path");

    // The RAM serves either a load or a pixel in one cycle, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("mask RAM written and read in the same cycle");

    // RAM writes stay inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (waddr32 < 32'(DEPTH)))
        else $error("mask load address outside the store");

    // An unmasked pixel reaches the output with its channels unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_vld_reg && o_rdy && !p_dark_reg) |=>
            (results.out_red == $past(p_red_reg) &&
             results.out_green == $past(p_green_reg) &&
             results.out_blue == $past(p_blue_reg)))
        else $error("unmasked pixel was altered");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmb_pkg::*;

    // Mask store geometry as built (DUT keeps its default parameters)
    localparam int TILE_MAX_W  = MASK_MAX_WIDTH_DEF;
    localparam int TILE_MAX_H  = MASK_MAX_HEIGHT_DEF;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    // A load lands in the mask RAM after the remainder stages and yields no result,
    // so an empty result queue is not enough before a register write.
    localparam int LOAD_SETTLE = 12;
    // Tail after the last result: pipeline is 8 deep
    localparam int DRAIN_TAIL  = 20;
    // Cycles with no transaction on either channel before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 29;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;
    // Phase that runs with both sides streaming back to back
    localparam int BURST_PHASE = 3;

    typedef struct packed {
        item_mode_t         mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               mask_dark;
    } pix_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Directed rows: a mask load, a pixel checked by the predictor, a pixel whose
    // result is written out by hand, or a tile register write (value in x).
    typedef enum logic [2:0] {
        ROW_LOAD,
        ROW_PIXEL,
        ROW_PIXEL_EXP,
        ROW_SET_W,
        ROW_SET_H
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               mask_dark;
        logic [CHAN_W-1:0]  exp_red;
        logic [CHAN_W-1:0]  exp_green;
        logic [CHAN_W-1:0]  exp_blue;
    } dir_row_t;

    // Tile starts at its reset size 64x64.
    // Scaled value is floor(v*29/20): 175 -> 253, 176 -> 255.2 -> 255, 177 saturates.
    localparam dir_row_t DIR_ROWS [25] = '{
        // mask setup; rgb is don't-care on loads
        '{ROW_LOAD,         0,    0, 255, 255, 255, 1,   0,   0,   0},
        '{ROW_LOAD,         1,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_LOAD,         0,    1,  17,  34,  51, 0,   0,   0,   0},
        '{ROW_LOAD,        63,   63,   0,   0,   0, 1,   0,   0,   0},
        // outside the store: must be dropped (x=64 would alias onto (0,1))
        '{ROW_LOAD,        64,    0,   0,   0,   0, 1,   0,   0,   0},
        '{ROW_LOAD,      4095, 4095, 255, 255, 255, 1,   0,   0,   0},
        // dark entry: saturation, zero, the rounding edge around 255
        '{ROW_PIXEL_EXP,    0,    0, 255, 255, 255, 0, 255, 255, 255},
        '{ROW_PIXEL_EXP,    0,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_PIXEL_EXP,    0,    0, 175, 176, 177, 0, 253, 255, 255},
        // clear entry passes through; mask_dark on a pixel is ignored
        '{ROW_PIXEL_EXP,    1,    0, 255,   0, 128, 1, 255,   0, 128},
        // (0,1) still clear after the dropped load
        '{ROW_PIXEL_EXP,    0,    1, 200,  10,   3, 0, 200,  10,   3},
        // large coordinates wrap: 4095 onto (63,63), the others onto (0,0) and (1,0)
        '{ROW_PIXEL_EXP, 4095, 4095,   1,  20,  40, 1,   1,  29,  58},
        '{ROW_PIXEL_EXP,   64, 4032, 100,   7, 140, 0, 145,  10, 203},
        '{ROW_PIXEL,     1345, 2880,  13,  14,  15, 1,   0,   0,   0},
        // zero tile size behaves as 1x1: everything maps onto (0,0)
        '{ROW_SET_W,        0,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_SET_H,        0,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_PIXEL_EXP, 4095, 4095,  20,  21,  22, 0,  29,  30,  31},
        '{ROW_PIXEL,     2730, 1365, 150, 151, 152, 1,   0,   0,   0},
        // oversized tile clamps to 64x64
        '{ROW_SET_W,      127,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_SET_H,      127,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_PIXEL_EXP, 4095, 4095, 100,  50,  25, 0, 145,  72,  36},
        // 1x2 tile
        '{ROW_SET_W,        1,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_SET_H,        2,    0,   0,   0,   0, 0,   0,   0,   0},
        '{ROW_PIXEL_EXP,  777,    3,   9,   8,   7, 0,   9,   8,   7},
        '{ROW_PIXEL,      777, 4094,  88,  99, 111, 0,   0,   0,   0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tmb_pix_if pix_ch ();
    tmb_res_if res_ch ();

    tiled_mask_brighten_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    // Shadow of the block: tile registers, mask bits, and which bits were loaded.
    // Pixels are only ever aimed at loaded entries; unloaded ones read as garbage.
    logic [CFG_DATA_W-1:0] tile_w_reg = CFG_DATA_W'(MASK_DIM_RESET);
    logic [CFG_DATA_W-1:0] tile_h_reg = CFG_DATA_W'(MASK_DIM_RESET);
    bit                    mask_bits  [TILE_MAX_W*TILE_MAX_H];
    bit                    mask_known [TILE_MAX_W*TILE_MAX_H];
    int                    known_slots [$];

    // Expected output pixels, oldest first
    rgb_t pending_rgb [$];

    int idle_pct     = IDLE_PCT;
    int errors       = 0;
    int quiet_cycles = 0;
    int load_count   = 0;
    int pixel_count  = 0;
    int dark_hits    = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
        if (v == 0)
        begin
            return 1;
        end
        if (v > lim)
        begin
            return lim;
        end
        return v;
    endfunction

    // x1.45 done exactly as *29/20, floored, clipped to 8 bits
    function automatic logic [CHAN_W-1:0] gain_chan(input logic [CHAN_W-1:0] v);
        int unsigned s;
        s = (int'(v) * 29) / 20;
        return (s > 255) ? {CHAN_W{1'b1}} : CHAN_W'(s);
    endfunction

    function automatic rgb_t brighten_under_mask(input pix_item_t it);
        int unsigned cx;
        int unsigned cy;
        rgb_t        res;
        cx  = it.x % eff_dim(tile_w_reg, TILE_MAX_W);
        cy  = it.y % eff_dim(tile_h_reg, TILE_MAX_H);
        res = '{it.red, it.green, it.blue};
        if (mask_bits[cy*TILE_MAX_W + cx])
        begin
            dark_hits++;
            res = '{gain_chan(it.red), gain_chan(it.green), gain_chan(it.blue)};
        end
        return res;
    endfunction

    // Channel values weighted toward 0, 255 and the band where x1.45 crosses 255
    function automatic logic [CHAN_W-1:0] pick_chan();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return '1;
        end
        if (roll < 4)
        begin
            return CHAN_W'($urandom_range(170, 180));
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    task automatic log_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // ---------------------------------------------------------------
    // Pixel channel driver. Returns at the edge the transaction is taken;
    // the next caller makes the only assignment to valid in that step.
    // ---------------------------------------------------------------
    task automatic send_item(input pix_item_t it, input bit typed, input rgb_t typed_rgb);
        int   slot;
        rgb_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.mode      <= it.mode;
        pix_ch.x         <= it.x;
        pix_ch.y         <= it.y;
        pix_ch.red       <= it.red;
        pix_ch.green     <= it.green;
        pix_ch.blue      <= it.blue;
        pix_ch.mask_dark <= it.mask_dark;
        @(posedge clk);
        while (!pix_ch.ready)
        begin
            @(posedge clk);
        end
        if (it.mode == MODE_LOAD)
        begin
            load_count++;
            // out-of-store loads are dropped by the block
            if (it.x < TILE_MAX_W && it.y < TILE_MAX_H)
            begin
                slot            = it.y*TILE_MAX_W + it.x;
                mask_bits[slot] = it.mask_dark;
                if (!mask_known[slot])
                begin
                    mask_known[slot] = 1'b1;
                    known_slots.push_back(slot);
                end
            end
        end
        else
        begin
            pixel_count++;
            predicted = brighten_under_mask(it);
            pending_rgb.push_back(typed ? typed_rgb : predicted);
        end
    endtask

    // Register write, only with the pipe empty and any trailing load settled
    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        pix_ch.valid <= 1'b0;
        while (pending_rgb.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LOAD_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TILE_W)
        begin
            tile_w_reg = CFG_DATA_W'(value);
        end
        else
        begin
            tile_h_reg = CFG_DATA_W'(value);
        end
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random back-pressure
    // ---------------------------------------------------------------
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Result checker and hang watchdog
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rgb_t want;
        rgb_t got;
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end

        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, pending_rgb.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            got = '{res_ch.out_red, res_ch.out_green, res_ch.out_blue};
            if (pending_rgb.size() == 0)
            begin
                log_error($sformatf("unexpected result rgb %0d/%0d/%0d",
                                    got.red, got.green, got.blue));
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue)
                begin
                    log_error($sformatf("result %0d: expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                                        results_seen, want.red, want.green, want.blue,
                                        got.red, got.green, got.blue));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        pix_item_t   it;
        dir_row_t    row;
        rgb_t        hand_rgb;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned roll;
        int unsigned mx;
        int unsigned my;
        int unsigned cx;
        int unsigned cy;
        int          slot;
        bit          found;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_TILE_W;
        cfg_data         <= '0;
        pix_ch.valid     <= 1'b0;
        pix_ch.mode      <= MODE_LOAD;
        pix_ch.x         <= '0;
        pix_ch.y         <= '0;
        pix_ch.red       <= '0;
        pix_ch.green     <= '0;
        pix_ch.blue      <= '0;
        pix_ch.mask_dark <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mask edges, dropped loads, saturation, tile clamping
        foreach (DIR_ROWS[i])
        begin
            row = DIR_ROWS[i];
            case (row.kind)
                ROW_SET_W: write_reg(REG_TILE_W, row.x);
                ROW_SET_H: write_reg(REG_TILE_H, row.x);
                default:
                begin
                    it.mode = MODE_PIXEL;
                    if (row.kind == ROW_LOAD)
                    begin
                        it.mode = MODE_LOAD;
                    end
                    it.x         = row.x;
                    it.y         = row.y;
                    it.red       = row.red;
                    it.green     = row.green;
                    it.blue      = row.blue;
                    it.mask_dark = row.mask_dark;
                    hand_rgb     = '{row.exp_red, row.exp_green, row.exp_blue};
                    send_item(it, row.kind == ROW_PIXEL_EXP, hand_rgb);
                end
            endcase
        end

        // Random phases, one tile setting each. Every phase opens with a burst
        // of loads, mostly inside the tile, so that pixels have loaded entries to hit.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_TILE_W, 64);  write_reg(REG_TILE_H, 64);  end
                1: begin write_reg(REG_TILE_W, 0);   write_reg(REG_TILE_H, 127); end
                2: begin write_reg(REG_TILE_W, 127); write_reg(REG_TILE_H, 0);   end
                3: begin write_reg(REG_TILE_W, 5);   write_reg(REG_TILE_H, 3);   end
                4: begin write_reg(REG_TILE_W, 1);   write_reg(REG_TILE_H, 1);   end
                5: begin write_reg(REG_TILE_W, 65);  write_reg(REG_TILE_H, 2);   end
                default:
                begin
                    write_reg(REG_TILE_W, $urandom_range(0, 127));
                    write_reg(REG_TILE_H, $urandom_range(0, 16));
                end
            endcase
            idle_pct = (ph == BURST_PHASE) ? 0 : IDLE_PCT;
            w_eff    = eff_dim(tile_w_reg, TILE_MAX_W);
            h_eff    = eff_dim(tile_h_reg, TILE_MAX_H);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it.red       = pick_chan();
                it.green     = pick_chan();
                it.blue      = pick_chan();
                it.mask_dark = 1'($urandom_range(0, 1));
                if (n < 10 || $urandom_range(0, 99) < 30)
                begin
                    it.mode = MODE_LOAD;
                    roll    = $urandom_range(0, 99);
                    if (roll < 70)
                    begin
                        it.x = COORD_W'($urandom_range(0, w_eff - 1));
                        it.y = COORD_W'($urandom_range(0, h_eff - 1));
                    end
                    else if (roll < 85)
                    begin
                        it.x = COORD_W'($urandom_range(0, TILE_MAX_W - 1));
                        it.y = COORD_W'($urandom_range(0, TILE_MAX_H - 1));
                    end
                    else if (roll < 93)
                    begin
                        // beyond the store: dropped
                        it.x = COORD_W'($urandom_range(TILE_MAX_W, COORD_MAX));
                        it.y = COORD_W'($urandom_range(0, COORD_MAX));
                    end
                    else
                    begin
                        it.x = COORD_W'($urandom_range(0, COORD_MAX));
                        it.y = COORD_W'($urandom_range(TILE_MAX_H, COORD_MAX));
                    end
                end
                else
                begin
                    // Aim at a loaded entry inside the tile; (0,0) always qualifies
                    it.mode = MODE_PIXEL;
                    found   = 1'b0;
                    mx      = 0;
                    my      = 0;
                    for (int t = 0; t < 8 && !found; t++)
                    begin
                        if (t % 2 == 1)
                        begin
                            slot = known_slots[$urandom_range(0, known_slots.size() - 1)];
                            cx   = slot % TILE_MAX_W;
                            cy   = slot / TILE_MAX_W;
                        end
                        else
                        begin
                            cx = $urandom_range(0, w_eff - 1);
                            cy = $urandom_range(0, h_eff - 1);
                        end
                        if (cx < w_eff && cy < h_eff && mask_known[cy*TILE_MAX_W + cx])
                        begin
                            found = 1'b1;
                            mx    = cx;
                            my    = cy;
                        end
                    end
                    // random tile repeat, anywhere in the 12-bit coordinate range
                    it.x = COORD_W'(mx + w_eff * $urandom_range(0, (COORD_MAX - mx) / w_eff));
                    it.y = COORD_W'(my + h_eff * $urandom_range(0, (COORD_MAX - my) / h_eff));
                end
                send_item(it, 1'b0, '0);
            end
        end

        // Drain: the watchdog covers results that never show up
        pix_ch.valid <= 1'b0;
        idle_pct = IDLE_PCT;
        while (pending_rgb.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Covered %0d mask loads and %0d pixels (%0d under a dark mask bit), %0d register writes",
                 load_count, pixel_count, dark_hits, cfg_writes);
        $display("Tile sizes from 0 (as 1) to 127 (as 64); %0d results checked, %0d errors",
                 results_seen, errors);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tmb_pkg.sv
design/tmb_if.sv
design/tmb_ram.sv
design/tiled_mask_brighten_core.sv
tb/tb_top.sv
